// File: design/ptc_pkg.sv
`timescale 1ns / 1ps
package ptc_pkg;

   localparam int DivSteps = 64;

   localparam logic [1:0] RegTempCoeffs    = 2'd0;
   localparam logic [1:0] RegPressCoeffsLo = 2'd1;
   localparam logic [1:0] RegPressCoeffsHi = 2'd2;
   localparam logic [1:0] RegPressCoeffNine = 2'd3;

   localparam logic [63:0] FineOffset = 64'd128000;
   localparam logic [20:0] PressFull  = 21'd1048576;
   localparam logic [63:0] DenBias    = 64'h0000_8000_0000_0000;
   localparam logic [31:0] RoundHalf  = 32'd128;
   localparam logic [11:0] ScaleNum   = 12'd3125;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coef_type;

   function automatic logic [63:0] sx16(input logic [15:0] c);
      return {{48{c[15]}}, c};
   endfunction

   function automatic logic [63:0] mul_s16(input logic [63:0] x, input logic [15:0] c);
      logic signed [79:0] t;
      t = $signed(x) * $signed(c);
      return t[63:0];
   endfunction

   function automatic logic [63:0] mul_u16(input logic [63:0] x, input logic [15:0] c);
      logic signed [79:0] t;
      t = $signed(x) * $signed({1'b0, c});
      return t[63:0];
   endfunction

endpackage

// File: design/ptc_mul64.sv
`timescale 1ns / 1ps
module ptc_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic [63:0] prod
);
   logic [63:0] lo_ff, lo_in;
   logic [31:0] mid_a_ff, mid_a_in;
   logic [31:0] mid_b_ff, mid_b_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] mid_sum;

   always_comb begin
      lo_in    = x[31:0] * y[31:0];
      mid_a_in = x[31:0] * y[63:32];
      mid_b_in = x[63:32] * y[31:0];
      mid_sum  = mid_a_ff + mid_b_ff;
      prod_in  = lo_ff + {mid_sum, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff    <= lo_in;
         mid_a_ff <= mid_a_in;
         mid_b_ff <= mid_b_in;
         prod_ff  <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule

// File: design/ptc_temp.sv
`timescale 1ns / 1ps
module ptc_temp
   import ptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  coef_type    coef,
   input  logic        in_valid,
   input  logic [19:0] in_adc_press,
   input  logic [19:0] in_adc_temp,
   output logic        out_valid,
   output logic [19:0] out_adc_press,
   output logic [15:0] out_tc,
   output logic [63:0] out_a
);
   logic [4:0]  vld_ff, vld_in;
   logic [19:0] adcp_ff [5];
   logic [31:0] x1_ff, x1_in, dd_ff, dd_in;
   logic [31:0] m1_ff, m1_in, m2_ff, m2_in;
   logic [31:0] v1_ff, v1_in, m3_ff, m3_in;
   logic [31:0] fine_ff, fine_in;
   logic [15:0] tc_ff, tc_in;
   logic [63:0] a_ff, a_in;
   logic [31:0] m2_sh, m3_sh, f5;

   always_comb begin
      vld_in = {vld_ff[3:0], in_valid};
      x1_in  = {15'd0, in_adc_temp[19:3]} - {15'd0, coef.t1, 1'b0};
      dd_in  = {16'd0, in_adc_temp[19:4]} - {16'd0, coef.t1};
      m1_in  = x1_ff * {{16{coef.t2[15]}}, coef.t2};
      m2_in  = dd_ff * dd_ff;
      v1_in  = $signed(m1_ff) >>> 11;
      m2_sh  = $signed(m2_ff) >>> 12;
      m3_in  = m2_sh * {{16{coef.t3[15]}}, coef.t3};
      m3_sh  = $signed(m3_ff) >>> 14;
      fine_in = v1_ff + m3_sh;
      f5     = {fine_ff[29:0], 2'b00} + fine_ff + RoundHalf;
      tc_in  = f5[23:8];
      a_in   = {{32{fine_ff[31]}}, fine_ff} - FineOffset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         adcp_ff[0] <= in_adc_press;
         for (int i = 1; i < 5; i++) begin
            adcp_ff[i] <= adcp_ff[i-1];
         end
         x1_ff   <= x1_in;
         dd_ff   <= dd_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         v1_ff   <= v1_in;
         m3_ff   <= m3_in;
         fine_ff <= fine_in;
         tc_ff   <= tc_in;
         a_ff    <= a_in;
      end
   end

   assign out_valid     = vld_ff[4];
   assign out_adc_press = adcp_ff[4];
   assign out_tc        = tc_ff;
   assign out_a         = a_ff;
endmodule

// File: design/ptc_pre.sv
`timescale 1ns / 1ps
module ptc_pre
   import ptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  coef_type    coef,
   input  logic        in_valid,
   input  logic [19:0] in_adc_press,
   input  logic [15:0] in_tc,
   input  logic [63:0] in_a,
   output logic        out_valid,
   output logic [15:0] out_tc,
   output logic [63:0] out_num,
   output logic [63:0] out_den
);
   logic [5:0]  vld_ff, vld_in;
   logic [15:0] tc_ff [6];
   logic [63:0] aa;
   logic [63:0] ap5_ff, ap5_in, ap2_ff, ap2_in;
   logic [63:0] bpart_ff, bpart_in, apart_ff, apart_in;
   logic [63:0] bpart3_ff, apart3_ff;
   logic [20:0] np_ff [4];
   logic [20:0] np_in;
   logic [63:0] b1_ff, b1_in, c1_ff, c1_in;
   logic [63:0] b_ff, b_in, a2_ff, a2_in;
   logic [63:0] sp_ff, sp_in, nb_ff, nb_in;
   logic [63:0] num_ff, num_in, den_ff, den_in;
   logic [63:0] c1_sh, nshift;

   ptc_mul64 u_aa (
      .clock (clock),
      .en    (en),
      .x     (in_a),
      .y     (in_a),
      .prod  (aa)
   );

   always_comb begin
      vld_in   = {vld_ff[4:0], in_valid};
      np_in    = PressFull - {1'b0, in_adc_press};
      ap5_in   = mul_s16(in_a, coef.p5);
      ap2_in   = mul_s16(in_a, coef.p2);
      bpart_in = {ap5_ff[46:0], 17'd0} + {{13{coef.p4[15]}}, coef.p4, 35'd0};
      apart_in = {ap2_ff[51:0], 12'd0};
      b1_in    = mul_s16(aa, coef.p6);
      c1_in    = mul_s16(aa, coef.p3);
      c1_sh    = $signed(c1_ff) >>> 8;
      b_in     = b1_ff + bpart3_ff;
      a2_in    = c1_sh + apart3_ff;
      sp_in    = mul_u16(DenBias + a2_ff, coef.p1);
      nshift   = {12'd0, np_ff[3], 31'd0};
      nb_in    = nshift - b_ff;
      den_in   = $signed(sp_ff) >>> 33;
      num_in   = mul_u16(nb_ff, {4'd0, ScaleNum});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tc_ff[0] <= in_tc;
         for (int i = 1; i < 6; i++) begin
            tc_ff[i] <= tc_ff[i-1];
         end
         np_ff[0] <= np_in;
         for (int i = 1; i < 4; i++) begin
            np_ff[i] <= np_ff[i-1];
         end
         ap5_ff    <= ap5_in;
         ap2_ff    <= ap2_in;
         bpart_ff  <= bpart_in;
         apart_ff  <= apart_in;
         bpart3_ff <= bpart_ff;
         apart3_ff <= apart_ff;
         b1_ff     <= b1_in;
         c1_ff     <= c1_in;
         b_ff      <= b_in;
         a2_ff     <= a2_in;
         sp_ff     <= sp_in;
         nb_ff     <= nb_in;
         num_ff    <= num_in;
         den_ff    <= den_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_tc    = tc_ff[5];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
endmodule

// File: design/ptc_div.sv
`timescale 1ns / 1ps
module ptc_div
   import ptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [15:0] in_tc,
   input  logic [63:0] in_num,
   input  logic [63:0] in_den,
   output logic        out_valid,
   output logic [15:0] out_tc,
   output logic [63:0] out_quot,
   output logic        out_zero
);
   logic        vld_ff  [DivSteps+1];
   logic [15:0] tc_ff   [DivSteps+1];
   logic        zero_ff [DivSteps+1];
   logic        neg_ff  [DivSteps+1];
   logic [63:0] d_ff    [DivSteps+1];
   logic [63:0] r_ff    [DivSteps+1];
   logic [63:0] nq_ff   [DivSteps+1];
   logic        vld_out_ff, zero_out_ff;
   logic [15:0] tc_out_ff;
   logic [63:0] quot_ff, quot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tc_ff[0]   <= in_tc;
         zero_ff[0] <= (in_den == 64'd0);
         neg_ff[0]  <= in_num[63] ^ in_den[63];
         nq_ff[0]   <= in_num[63] ? (64'd0 - in_num) : in_num;
         d_ff[0]    <= in_den[63] ? (64'd0 - in_den) : in_den;
         r_ff[0]    <= 64'd0;
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [64:0] rs;
      logic        ge;
      logic [64:0] diff;
      always_comb begin
         rs   = {r_ff[k], nq_ff[k][63]};
         diff = rs - {1'b0, d_ff[k]};
         ge   = !diff[64];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tc_ff[k+1]   <= tc_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            d_ff[k+1]    <= d_ff[k];
            r_ff[k+1]    <= ge ? diff[63:0] : rs[63:0];
            nq_ff[k+1]   <= {nq_ff[k][62:0], ge};
         end
      end
   end

   assign quot_in = neg_ff[DivSteps] ? (64'd0 - nq_ff[DivSteps]) : nq_ff[DivSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else if (en) begin
         vld_out_ff <= vld_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tc_out_ff   <= tc_ff[DivSteps];
         zero_out_ff <= zero_ff[DivSteps];
         quot_ff     <= quot_in;
      end
   end

   assign out_valid = vld_out_ff;
   assign out_tc    = tc_out_ff;
   assign out_quot  = quot_ff;
   assign out_zero  = zero_out_ff;
endmodule

// File: design/ptc_post.sv
`timescale 1ns / 1ps
module ptc_post
   import ptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  coef_type    coef,
   input  logic        in_valid,
   input  logic [15:0] in_tc,
   input  logic [63:0] in_quot,
   input  logic        in_zero,
   output logic        out_valid,
   output logic [15:0] out_temp_centi_c,
   output logic [31:0] out_pressure_pa,
   output logic        out_divisor_zero
);
   logic [5:0]  vld_ff, vld_in;
   logic [15:0] tc_ff   [6];
   logic        zero_ff [6];
   logic [63:0] p_ff    [3];
   logic [63:0] ep_ff   [3];
   logic [63:0] ep_in, h, hh;
   logic [63:0] c0_ff, c0_in, sum_ff, sum_in, pp_ff, pp_in;
   logic [31:0] press_ff, press_in;
   logic [63:0] c0_sh, ep_sh, sum_sh;

   ptc_mul64 u_hh (
      .clock (clock),
      .en    (en),
      .x     (h),
      .y     (h),
      .prod  (hh)
   );

   always_comb begin
      vld_in   = {vld_ff[4:0], in_valid};
      h        = $signed(in_quot) >>> 13;
      ep_in    = mul_s16(in_quot, coef.p8);
      c0_in    = mul_s16(hh, coef.p9);
      c0_sh    = $signed(c0_ff) >>> 25;
      ep_sh    = $signed(ep_ff[2]) >>> 19;
      sum_in   = p_ff[2] + c0_sh + ep_sh;
      sum_sh   = $signed(sum_ff) >>> 8;
      pp_in    = sum_sh + {{44{coef.p7[15]}}, coef.p7, 4'd0};
      press_in = zero_ff[4] ? 32'd0 : pp_ff[39:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tc_ff[0]   <= in_tc;
         zero_ff[0] <= in_zero;
         for (int i = 1; i < 6; i++) begin
            tc_ff[i]   <= tc_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
         p_ff[0]  <= in_quot;
         ep_ff[0] <= ep_in;
         for (int i = 1; i < 3; i++) begin
            p_ff[i]  <= p_ff[i-1];
            ep_ff[i] <= ep_ff[i-1];
         end
         c0_ff    <= c0_in;
         sum_ff   <= sum_in;
         pp_ff    <= pp_in;
         press_ff <= press_in;
      end
   end

   assign out_valid        = vld_ff[5];
   assign out_temp_centi_c = tc_ff[5];
   assign out_pressure_pa  = press_ff;
   assign out_divisor_zero = zero_ff[5];
endmodule

// File: design/pressure_temp_compensation.sv
`timescale 1ns / 1ps
// Integer compensation of raw pressure and temperature converter readings.
// Load the four calibration registers through the csr_ port (csr_ready is
// always high) while no item is in flight.
// Request channel: req_valid with req_adc_press and req_adc_temp; an item is
// taken at a clock edge where req_valid is high and req_stall is low.
// Response channel: rsp_valid with temperature in hundredths of a degree,
// pressure in pascal and a divisor_zero flag; the item is taken when
// rsp_stall is low. divisor_zero forces pressure to 0.
// One item per cycle is sustained unless the output stalls. The 64-step
// restoring divider, one quotient bit per stage, sets most of the depth.
// The whole pipeline advances together. While rsp_valid is high and
// rsp_stall is high, every stage holds and req_stall is raised; a bubble at
// the output lets the pipe advance regardless of rsp_stall.
// Synchronous reset clears all valid bits and the calibration registers.
module pressure_temp_compensation
   import ptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_adc_press,
   input  logic [19:0] req_adc_temp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_temp_centi_c,
   output logic [31:0] rsp_pressure_pa,
   output logic        rsp_divisor_zero,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_lo_ff, press_hi_ff;
   logic [15:0] press_nine_ff;
   coef_type    coef;
   logic        en;

   logic        t_valid;
   logic [19:0] t_adc_press;
   logic [15:0] t_tc;
   logic [63:0] t_a;
   logic        q_valid;
   logic [15:0] q_tc;
   logic [63:0] q_num, q_den;
   logic        d_valid, d_zero;
   logic [15:0] d_tc;
   logic [63:0] d_quot;

   assign csr_ready = 1'b1;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_lo_ff    <= '0;
         press_hi_ff    <= '0;
         press_nine_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegTempCoeffs:     temp_coeffs_ff <= csr_data[47:0];
            RegPressCoeffsLo:  press_lo_ff    <= csr_data;
            RegPressCoeffsHi:  press_hi_ff    <= csr_data;
            RegPressCoeffNine: press_nine_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.t1 = temp_coeffs_ff[15:0];
      coef.t2 = temp_coeffs_ff[31:16];
      coef.t3 = temp_coeffs_ff[47:32];
      coef.p1 = press_lo_ff[15:0];
      coef.p2 = press_lo_ff[31:16];
      coef.p3 = press_lo_ff[47:32];
      coef.p4 = press_lo_ff[63:48];
      coef.p5 = press_hi_ff[15:0];
      coef.p6 = press_hi_ff[31:16];
      coef.p7 = press_hi_ff[47:32];
      coef.p8 = press_hi_ff[63:48];
      coef.p9 = press_nine_ff;
   end

   ptc_temp u_temp (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .coef          (coef),
      .in_valid      (req_valid && en),
      .in_adc_press  (req_adc_press),
      .in_adc_temp   (req_adc_temp),
      .out_valid     (t_valid),
      .out_adc_press (t_adc_press),
      .out_tc        (t_tc),
      .out_a         (t_a)
   );

   ptc_pre u_pre (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .coef         (coef),
      .in_valid     (t_valid),
      .in_adc_press (t_adc_press),
      .in_tc        (t_tc),
      .in_a         (t_a),
      .out_valid    (q_valid),
      .out_tc       (q_tc),
      .out_num      (q_num),
      .out_den      (q_den)
   );

   ptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_valid),
      .in_tc     (q_tc),
      .in_num    (q_num),
      .in_den    (q_den),
      .out_valid (d_valid),
      .out_tc    (d_tc),
      .out_quot  (d_quot),
      .out_zero  (d_zero)
   );

   ptc_post u_post (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .coef             (coef),
      .in_valid         (d_valid),
      .in_tc            (d_tc),
      .in_quot          (d_quot),
      .in_zero          (d_zero),
      .out_valid        (rsp_valid),
      .out_temp_centi_c (rsp_temp_centi_c),
      .out_pressure_pa  (rsp_pressure_pa),
      .out_divisor_zero (rsp_divisor_zero)
   );
endmodule

// File: dv/pressure_temp_compensation_tb.sv
`timescale 1ns / 1ps
module pressure_temp_compensation_tb
   import ptc_pkg::*;
();

   typedef struct packed {
      logic [19:0] adc_press;
      logic [19:0] adc_temp;
   } reading_type;

   typedef struct packed {
      logic [15:0] temp_centi_c;
      logic [31:0] pressure_pa;
      logic        divisor_zero;
   } comp_type;

   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 120;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [19:0] req_adc_press;
   logic [19:0] req_adc_temp;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_temp_centi_c;
   logic [31:0] rsp_pressure_pa;
   logic        rsp_divisor_zero;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   logic [47:0] cal_temp;
   logic [63:0] cal_lo;
   logic [63:0] cal_hi;
   logic [15:0] cal_nine;

   reading_type readings_pending[$];
   comp_type    comps_due[$];
   int       send_gap;
   int       stall_left;
   bit       steady;
   int       mismatches;
   int       items_sent;
   int       comps_seen;
   int       zero_div_seen;
   int       settings_used;
   longint   cycles;

   pressure_temp_compensation dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [63:0] sdiv_trunc(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] un;
      logic [63:0] ud;
      logic [63:0] q;
      un = n[63] ? -n : n;
      ud = d[63] ? -d : d;
      q = un / ud;
      return (n[63] ^ d[63]) ? -q : q;
   endfunction

   function automatic logic [63:0] sext(input logic [15:0] c);
      return {{48{c[15]}}, c};
   endfunction

   function automatic comp_type compensate(input reading_type r);
      comp_type res;
      logic [31:0] t1, t2, t3, x, d, v1, v2, fine, tc;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, p, c, e, w, s;
      t1 = {16'b0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      x = ({12'b0, r.adc_temp} >> 3) - (t1 << 1);
      x = x * t2;
      v1 = $signed(x) >>> 11;
      d = ({12'b0, r.adc_temp} >> 4) - t1;
      x = d * d;
      x = $signed(x) >>> 12;
      x = x * t3;
      v2 = $signed(x) >>> 14;
      fine = v1 + v2;
      x = fine * 32'd5 + 32'd128;
      tc = $signed(x) >>> 8;

      p1 = {48'b0, cal_lo[15:0]};
      p2 = sext(cal_lo[31:16]);
      p3 = sext(cal_lo[47:32]);
      p4 = sext(cal_lo[63:48]);
      p5 = sext(cal_hi[15:0]);
      p6 = sext(cal_hi[31:16]);
      p7 = sext(cal_hi[47:32]);
      p8 = sext(cal_hi[63:48]);
      p9 = sext(cal_nine);

      a = {{32{fine[31]}}, fine} - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      w = a * a * p3;
      s = $signed(w) >>> 8;
      a = s + ((a * p2) << 12);
      w = (64'h0000_8000_0000_0000 + a) * p1;
      a = $signed(w) >>> 33;

      res.temp_centi_c = tc[15:0];
      res.pressure_pa = 32'd0;
      res.divisor_zero = 1'b0;
      if (a == 64'd0) begin
         res.divisor_zero = 1'b1;
      end else begin
         p = 64'd1048576 - {44'b0, r.adc_press};
         p = ((p << 31) - b) * 64'd3125;
         p = sdiv_trunc(p, a);
         s = $signed(p) >>> 13;
         c = p9 * s * s;
         c = $signed(c) >>> 25;
         e = p8 * p;
         e = $signed(e) >>> 19;
         w = p + c + e;
         w = $signed(w) >>> 8;
         w = w + (p7 << 4);
         w = $signed(w) >>> 8;
         res.pressure_pa = w[31:0];
      end
      return res;
   endfunction

   function automatic int draw_gap();
      int k;
      k = $urandom_range(0, 19);
      if (steady || k < 12) return 0;
      if (k < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            comps_due.push_back(compensate({req_adc_press, req_adc_temp}));
            items_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (readings_pending.size() > 0) begin
               reading_type r;
               r = readings_pending.pop_front();
               req_adc_press <= r.adc_press;
               req_adc_temp <= r.adc_temp;
               req_valid <= 1'b1;
               send_gap <= draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            comps_seen++;
            if (rsp_divisor_zero) zero_div_seen++;
            if (comps_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: temp %0d press %0d flag %0b",
                     $signed(rsp_temp_centi_c), rsp_pressure_pa, rsp_divisor_zero);
            end else begin
               comp_type want;
               want = comps_due.pop_front();
               if (want.temp_centi_c !== rsp_temp_centi_c ||
                     want.pressure_pa !== rsp_pressure_pa ||
                     want.divisor_zero !== rsp_divisor_zero) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: temp %0d/%0d press %0d/%0d flag %0b/%0b",
                        $signed(want.temp_centi_c), $signed(rsp_temp_centi_c),
                        want.pressure_pa, rsp_pressure_pa,
                        want.divisor_zero, rsp_divisor_zero);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!steady && $urandom_range(0, 9) < 3) begin
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(8, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout with %0d results outstanding", comps_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         RegTempCoeffs:     cal_temp = value[47:0];
         RegPressCoeffsLo:  cal_lo = value;
         RegPressCoeffsHi:  cal_hi = value;
         RegPressCoeffNine: cal_nine = value[15:0];
      endcase
   endtask

   task automatic load_calibration(input logic [63:0] t, input logic [63:0] lo,
         input logic [63:0] hi, input logic [63:0] nine);
      wait (readings_pending.size() == 0 && !req_valid && comps_due.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      write_reg(RegTempCoeffs, t);
      write_reg(RegPressCoeffsLo, lo);
      write_reg(RegPressCoeffsHi, hi);
      write_reg(RegPressCoeffNine, nine);
      settings_used++;
   endtask

   task automatic queue_random(input int n);
      reading_type r;
      for (int i = 0; i < n; i++) begin
         r.adc_press = 20'($urandom_range(0, 20'hfffff));
         r.adc_temp = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 20'hfffff))
                                                  : 20'($urandom_range(20'h6_0000, 20'h9_0000));
         readings_pending.push_back(r);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   localparam logic [63:0] TypTemp = {16'h0000, 16'hfc18, 16'd26435, 16'd27504};
   localparam logic [63:0] TypLo   = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
   localparam logic [63:0] TypHi   = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};
   localparam logic [63:0] TypNine = 64'd6000;

   initial begin
      reading_type r;
      logic [19:0] edges[6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_adc_press = '0;
      req_adc_temp = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = RegTempCoeffs;
      csr_data = '0;
      cal_temp = '0;
      cal_lo = '0;
      cal_hi = '0;
      cal_nine = '0;
      mismatches = 0;
      items_sent = 0;
      comps_seen = 0;
      zero_div_seen = 0;
      settings_used = 0;
      cycles = 0;
      steady = 1'b0;
      edges = '{20'h00000, 20'hfffff, 20'h80000, 20'h7ffff, 20'h7e0f0, 20'h51eb0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: divisor is zero
      for (int i = 0; i < 4; i++) begin
         r.adc_press = edges[i];
         r.adc_temp = edges[3 - i];
         readings_pending.push_back(r);
      end
      load_calibration(TypTemp, TypLo, TypHi, TypNine);
      for (int i = 0; i < 6; i++) begin
         r.adc_press = edges[i];
         r.adc_temp = edges[(i + 3) % 6];
         readings_pending.push_back(r);
         r.adc_temp = edges[i];
         readings_pending.push_back(r);
      end
      queue_random(200);
      load_calibration(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                       64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      for (int i = 0; i < 4; i++) begin
         r.adc_press = edges[i];
         r.adc_temp = edges[i ^ 1];
         readings_pending.push_back(r);
      end
      queue_random(100);
      load_calibration(64'h7fff_8000_7fff, 64'h7fff_8000_7fff_ffff,
                       64'h8000_7fff_8000_7fff, 64'h8000);
      queue_random(120);
      // no idling on either side
      steady = 1'b1;
      load_calibration(TypTemp, TypLo, TypHi, TypNine);
      queue_random(200);
      wait (readings_pending.size() == 0);
      steady = 1'b0;
      for (int k = 0; k < 5; k++) begin
         load_calibration(rand64(), rand64() | 64'h1, rand64(), rand64());
         queue_random(120);
      end
      load_calibration(TypTemp ^ ($urandom() & 64'h00ff_00ff), TypLo, TypHi, TypNine);
      queue_random(150);

      wait (readings_pending.size() == 0 && !req_valid && comps_due.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d readings sent, %0d results checked (%0d with zero divisor)",
         items_sent, comps_seen, zero_div_seen);
      $display("%0d calibration settings, %0d mismatches", settings_used, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
design/ptc_pkg.sv
design/ptc_mul64.sv
design/ptc_temp.sv
design/ptc_pre.sv
design/ptc_div.sv
design/ptc_post.sv
design/pressure_temp_compensation.sv
dv/pressure_temp_compensation_tb.sv
